// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_ON(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/core/cdg_pkg.sv =====
package cdg_pkg;

  localparam int PIXEL_PORT_BITS = 16;
  localparam int DIM_BITS        = 11;
  localparam int COORD_BITS      = 10;
  localparam int GRAD_BITS       = 17;
  localparam int MAG_BITS        = 17;
  localparam int SUM_BITS        = 48;
  localparam int SQ_BITS         = 34;
  localparam int REM_BITS        = 20;
  localparam int SQRT_STEPS      = 17;
  localparam int CFG_IDX_BITS    = 2;
  localparam int DIM_LIMIT       = 1024;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NORM_MODE    = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_second;
    logic latch_a;
    logic calc;
    logic square;
    logic load;
    logic root_step;
    logic emit;
  } cdg_cmd_t;

  typedef struct packed {
    logic emit_now;
    logic norm;
    logic out_free;
  } cdg_status_t;

endpackage

// ===== rtl/core/cdg_ram.sv =====
module cdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cdg_ctrl.sv =====
module cdg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  cdg_pkg::cdg_status_t status,
  output cdg_pkg::cdg_cmd_t    cmd
);
  import cdg_pkg::*;

  typedef enum logic [2:0] {
    IDLE, READ_A, READ_B, CALC, SQUARE, LOAD, ROOT, EMIT
  } state_t;

  localparam int CNT_BITS = $clog2(SQRT_STEPS);

  state_t              state;
  logic [CNT_BITS-1:0] cnt;

  assign item_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (item_valid) begin
            state <= READ_A;
          end
        end
        READ_A: state <= READ_B;
        READ_B: state <= CALC;
        CALC: begin
          if (!status.emit_now) begin
            state <= IDLE;
          end else if (status.norm) begin
            state <= SQUARE;
          end else begin
            state <= EMIT;
          end
        end
        SQUARE: state <= LOAD;
        LOAD: begin
          cnt   <= '0;
          state <= ROOT;
        end
        ROOT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(SQRT_STEPS - 1)) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == IDLE) && item_valid;
    cmd.rd_second = (state == READ_B);
    cmd.latch_a   = (state == READ_B);
    cmd.calc      = (state == CALC);
    cmd.square    = (state == SQUARE);
    cmd.load      = (state == LOAD);
    cmd.root_step = (state == ROOT);
    cmd.emit      = (state == EMIT) && status.out_free;
  end

endmodule

// ===== rtl/core/cdg_datapath.sv =====
module cdg_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cdg_pkg::cdg_cmd_t                      cmd,
  output cdg_pkg::cdg_status_t                   status,
  input  logic                                   func,
  input  logic [cdg_pkg::PIXEL_PORT_BITS-1:0]    pixel,
  input  logic                                   cfg_we,
  input  logic [cdg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [cdg_pkg::DIM_BITS-1:0]           cfg_data,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [cdg_pkg::COORD_BITS-1:0]         out_row,
  output logic [cdg_pkg::COORD_BITS-1:0]         out_col,
  output logic signed [cdg_pkg::GRAD_BITS-1:0]   grad_rows,
  output logic signed [cdg_pkg::GRAD_BITS-1:0]   grad_cols,
  output logic [cdg_pkg::MAG_BITS-1:0]           magnitude,
  output logic [cdg_pkg::SUM_BITS-1:0]           frame_sum,
  output logic                                   last_of_frame
);
  import cdg_pkg::*;

  localparam int SB    = (PIXEL_BITS < PIXEL_PORT_BITS) ? PIXEL_BITS : PIXEL_PORT_BITS;
  localparam int DEPTH = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int AW    = $clog2(DEPTH);

  logic [DIM_BITS-1:0]   fw, fh, w_eff, h_eff;
  logic                  norm;
  logic [COORD_BITS-1:0] in_row, in_col;
  logic [DIM_BITS-1:0]   pending;
  logic [SB-1:0]         prior, pix_q, older_a, recent_c, older_rd, recent_rd;
  logic                  func_q;
  logic [SUM_BITS-1:0]   sum;

  logic [COORD_BITS-1:0]       r_q, c_q;
  logic signed [GRAD_BITS-1:0] gr_q, gc_q;
  logic [MAG_BITS-1:0]         l1_q;
  logic                        last_q;
  logic [2*PIXEL_PORT_BITS-1:0] sq_r, sq_c;
  logic [SQ_BITS-1:0]          v;
  logic [REM_BITS-1:0]         rem;
  logic [MAG_BITS-1:0]         root;

  // config and effective size
  always_ff @(posedge clk) begin
    if (rst) begin
      fw   <= DIM_BITS'(DIM_LIMIT);
      fh   <= DIM_BITS'(DIM_LIMIT);
      norm <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw   <= cfg_data;
        CFG_FRAME_HEIGHT: fh   <= cfg_data;
        CFG_NORM_MODE:    norm <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = fw;
    if (fw < DIM_BITS'(3)) w_eff = DIM_BITS'(3);
    if (fw > DIM_BITS'(DEPTH)) w_eff = DIM_BITS'(DEPTH);
    h_eff = fh;
    if (fh < DIM_BITS'(3)) h_eff = DIM_BITS'(3);
    if (fh > DIM_BITS'(DIM_LIMIT)) h_eff = DIM_BITS'(DIM_LIMIT);
  end

  // line stores
  logic [COORD_BITS-1:0] pc, old_raddr, rec_raddr;
  logic                  mem_we;

  assign pc        = (in_col != '0) ? in_col - 1'b1 : COORD_BITS'(w_eff - 1'b1);
  assign old_raddr = cmd.rd_second ? in_col - COORD_BITS'(2) : in_col - 1'b1;
  assign rec_raddr = cmd.rd_second ? pc : in_col;
  assign mem_we    = cmd.calc && !func_q;

  cdg_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_older (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pc[AW-1:0]),
    .wdata (recent_rd),
    .raddr (old_raddr[AW-1:0]),
    .rdata (older_rd)
  );

  cdg_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_recent (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pc[AW-1:0]),
    .wdata (prior),
    .raddr (rec_raddr[AW-1:0]),
    .rdata (recent_rd)
  );

  // per item decision
  logic [DIM_BITS:0]           wp1, pend12, pend_c;
  logic                        draining, full, ok, interior, emit_now;
  logic [COORD_BITS-1:0]       r_c, c_c;
  logic [DIM_BITS-1:0]         pending_next;
  logic signed [GRAD_BITS-1:0] gr_c, gc_c;
  logic [GRAD_BITS-1:0]        ar, ac;

  always_comb begin
    wp1      = (DIM_BITS+1)'(w_eff) + 1'b1;
    pend12   = (DIM_BITS+1)'(pending);
    pend_c   = (pend12 > wp1) ? wp1 : pend12;
    full     = (pend12 >= wp1);
    draining = (in_row == '0) && (in_col == '0) && (pending != '0);
    ok       = 1'b1;
    if (func_q) begin
      if (pend_c == wp1) begin
        r_c = COORD_BITS'(h_eff - DIM_BITS'(2));
        c_c = COORD_BITS'(w_eff - 1'b1);
      end else begin
        r_c = COORD_BITS'(h_eff - 1'b1);
        c_c = COORD_BITS'((DIM_BITS+1)'(w_eff) - pend_c);
      end
    end else if (in_col != '0) begin
      ok  = (in_row != '0);
      r_c = ok ? in_row - 1'b1 : '0;
      c_c = in_col - 1'b1;
    end else begin
      ok  = (in_row >= COORD_BITS'(2));
      r_c = ok ? in_row - COORD_BITS'(2) : '0;
      c_c = COORD_BITS'(w_eff - 1'b1);
    end
    interior = !func_q && ok && (in_col >= COORD_BITS'(2)) && (r_c != '0) &&
               ({1'b0, r_c} <= h_eff - DIM_BITS'(2)) &&
               ({1'b0, c_c} <= w_eff - DIM_BITS'(2));
    gr_c = interior ? signed'(GRAD_BITS'(prior) - GRAD_BITS'(older_a)) : '0;
    gc_c = interior ? signed'(GRAD_BITS'(recent_c) - GRAD_BITS'(older_rd)) : '0;
    emit_now = func_q ? draining : (!draining && full);
    if (func_q) begin
      pending_next = draining ? DIM_BITS'(pend_c - 1'b1) : pending;
    end else if (draining) begin
      pending_next = DIM_BITS'(1);
    end else if (full) begin
      pending_next = pending;
    end else begin
      pending_next = pending + 1'b1;
    end
    ar = gr_q[GRAD_BITS-1] ? GRAD_BITS'(-gr_q) : GRAD_BITS'(gr_q);
    ac = gc_q[GRAD_BITS-1] ? GRAD_BITS'(-gc_q) : GRAD_BITS'(gc_q);
  end

  assign status.emit_now = emit_now;
  assign status.norm     = norm;
  assign status.out_free = !result_valid || !result_stall;

  // root step and sum
  logic [REM_BITS-1:0] rem_sh, trial;
  logic [MAG_BITS-1:0] mag;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] frame_sum_next;

  assign rem_sh   = {rem[REM_BITS-3:0], v[SQ_BITS-1 -: 2]};
  assign trial    = REM_BITS'({root, 2'b01});
  assign mag      = norm ? root : l1_q;
  assign sum_wide = (SUM_BITS+1)'(sum) + (SUM_BITS+1)'(mag);
  assign frame_sum_next = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  // item state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      pending <= '0;
      prior   <= '0;
      sum     <= '0;
    end else begin
      if (cmd.capture) begin
        if ({1'b0, in_col} >= w_eff) in_col <= COORD_BITS'(w_eff - 1'b1);
        if ({1'b0, in_row} >= h_eff) in_row <= COORD_BITS'(h_eff - 1'b1);
      end
      if (cmd.calc) begin
        pending <= pending_next;
        if (!func_q) begin
          if (draining) sum <= '0;
          prior <= pix_q;
          if ({1'b0, in_col} + 1'b1 >= w_eff) begin
            in_col <= '0;
            in_row <= ({1'b0, in_row} + 1'b1 >= h_eff) ? '0 : in_row + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        sum <= last_q ? '0 : frame_sum_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      pix_q  <= pixel[SB-1:0];
    end
    if (cmd.latch_a) begin
      older_a  <= older_rd;
      recent_c <= recent_rd;
    end
    if (cmd.calc) begin
      r_q    <= r_c;
      c_q    <= c_c;
      gr_q   <= gr_c;
      gc_q   <= gc_c;
      last_q <= ({1'b0, r_c} == h_eff - 1'b1) && ({1'b0, c_c} == w_eff - 1'b1);
    end
    if (cmd.square) begin
      l1_q <= MAG_BITS'(ar + ac);
      sq_r <= ar[PIXEL_PORT_BITS-1:0] * ar[PIXEL_PORT_BITS-1:0];
      sq_c <= ac[PIXEL_PORT_BITS-1:0] * ac[PIXEL_PORT_BITS-1:0];
    end else if (cmd.calc) begin
      l1_q <= MAG_BITS'(GRAD_BITS'(gr_c[GRAD_BITS-1] ? -gr_c : gr_c) +
                        GRAD_BITS'(gc_c[GRAD_BITS-1] ? -gc_c : gc_c));
    end
    if (cmd.load) begin
      v    <= SQ_BITS'(sq_r) + SQ_BITS'(sq_c);
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      v <= v << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MAG_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row       <= r_q;
      out_col       <= c_q;
      grad_rows     <= gr_q;
      grad_cols     <= gc_q;
      magnitude     <= mag;
      frame_sum     <= frame_sum_next;
      last_of_frame <= last_q;
    end
  end

endmodule

// ===== rtl/core/central_difference_gradient_magnitude.sv =====
// channel   direction  handshake               payload
// item      in         item_valid/item_stall   func, pixel
// result    out        result_valid/result_stall  out_row .. last_of_frame
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// an item with no result runs read_a, read_b and calc; an l1 result adds emit,
// an l2 result adds square, load, root and emit: two line store reads, then a
// bit-serial root of 17 steps; a held result costs nothing until the next one is due
// rst is synchronous; the line stores are not cleared, no sweep after reset
// result_stall holds the result register; item_stall is high while busy
module central_difference_gradient_magnitude #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 func,
  input  logic [cdg_pkg::PIXEL_PORT_BITS-1:0]  pixel,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [cdg_pkg::COORD_BITS-1:0]       out_row,
  output logic [cdg_pkg::COORD_BITS-1:0]       out_col,
  output logic signed [cdg_pkg::GRAD_BITS-1:0] grad_rows,
  output logic signed [cdg_pkg::GRAD_BITS-1:0] grad_cols,
  output logic [cdg_pkg::MAG_BITS-1:0]         magnitude,
  output logic [cdg_pkg::SUM_BITS-1:0]         frame_sum,
  output logic                                 last_of_frame,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cdg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cdg_pkg::DIM_BITS-1:0]         cfg_data
);
  import cdg_pkg::*;

  cdg_cmd_t    cmd;
  cdg_status_t status;

  assign cfg_ready = 1'b1;

  cdg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  cdg_datapath #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .pixel         (pixel),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .grad_rows     (grad_rows),
    .grad_cols     (grad_cols),
    .magnitude     (magnitude),
    .frame_sum     (frame_sum),
    .last_of_frame (last_of_frame)
  );

endmodule

// ===== rtl/core/cdg_checker.sv =====
`include "assert_macros.svh"

module cdg_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [cdg_pkg::GRAD_BITS-1:0] grad_rows,
  input logic signed [cdg_pkg::GRAD_BITS-1:0] grad_cols,
  input logic [cdg_pkg::MAG_BITS-1:0]         magnitude,
  input logic                                 last_of_frame
);

  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid && !item_stall)
  `ASSERT_ON(a_busy_after_request, clk, rst, item_valid && !item_stall |=> item_stall)
  `ASSERT_ON(a_zero_grad_zero_mag, clk, rst, result_valid && grad_rows == '0 && grad_cols == '0 |-> magnitude == '0)
  `ASSERT_ON(a_last_on_border, clk, rst, result_valid && last_of_frame |-> grad_rows == '0 && grad_cols == '0)
  `ASSERT_ON(a_result_held, clk, rst, result_valid && result_stall |=> result_valid)

endmodule

bind central_difference_gradient_magnitude cdg_checker u_chk (.*);

// ===== verif/tb_central_difference_gradient_magnitude.sv =====
module tb_central_difference_gradient_magnitude;
  timeunit 1ns;
  timeprecision 1ps;
  import cdg_pkg::*;

  typedef struct {
    logic [COORD_BITS-1:0]       row;
    logic [COORD_BITS-1:0]       col;
    logic signed [GRAD_BITS-1:0] gr;
    logic signed [GRAD_BITS-1:0] gc;
    logic [MAG_BITS-1:0]         mag;
    logic [SUM_BITS-1:0]         sum;
    logic                        last;
  } grad_result_t;

  typedef struct {
    bit          drain;
    logic [15:0] px;
    bit          typed;
    int          row;
    int          col;
    int          gr;
    int          gc;
    int          mag;
    bit          last;
  } directed_row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam longint unsigned SUM_CEIL = 48'hFFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic func;
  logic [PIXEL_PORT_BITS-1:0] pixel;
  logic result_valid;
  logic result_stall;
  logic [COORD_BITS-1:0] out_row;
  logic [COORD_BITS-1:0] out_col;
  logic signed [GRAD_BITS-1:0] grad_rows;
  logic signed [GRAD_BITS-1:0] grad_cols;
  logic [MAG_BITS-1:0] magnitude;
  logic [SUM_BITS-1:0] frame_sum;
  logic last_of_frame;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0] cfg_data;

  central_difference_gradient_magnitude DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .func(func), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_row(out_row), .out_col(out_col), .grad_rows(grad_rows), .grad_cols(grad_cols),
    .magnitude(magnitude), .frame_sum(frame_sum), .last_of_frame(last_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // model state
  logic [15:0] older_mem [DIM_LIMIT];
  logic [15:0] recent_mem [DIM_LIMIT];
  int prior_px, row_ptr, col_ptr, pending;
  longint unsigned sum_acc;
  int width_reg, height_reg;
  bit l2_mode;

  grad_result_t gradient_q[$];
  int mismatches, item_count, result_count, frame_count;
  int send_idle, recv_idle, idle_cycles;
  bit hold_req;
  int hold_left;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic grad_result_t make_result(int r, int c, int gr, int gc, int w, int h);
    longint unsigned ar, ac, m;
    grad_result_t o;
    ar = (gr < 0) ? -gr : gr;
    ac = (gc < 0) ? -gc : gc;
    m = l2_mode ? int_sqrt(ar * ar + ac * ac) : ar + ac;
    if (m > 131070) m = 131070;
    sum_acc += m;
    if (sum_acc > SUM_CEIL) sum_acc = SUM_CEIL;
    o.row = COORD_BITS'(r);
    o.col = COORD_BITS'(c);
    o.gr = GRAD_BITS'(gr);
    o.gc = GRAD_BITS'(gc);
    o.mag = MAG_BITS'(m);
    o.sum = SUM_BITS'(sum_acc);
    o.last = (r == h - 1) && (c == w - 1);
    if (o.last) sum_acc = 0;
    return o;
  endfunction

  function automatic int clamp_dim(int v);
    return (v < 3) ? 3 : (v > DIM_LIMIT) ? DIM_LIMIT : v;
  endfunction

  function automatic int sat_grad(int g);
    return (g > 65535) ? 65535 : (g < -65535) ? -65535 : g;
  endfunction

  function automatic void gradient_step(bit drain, logic [15:0] px, output bit made,
                                        output grad_result_t o);
    int w, h, r, c, rr, cc, gr, gc, pc;
    bit draining, ok;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    made = 0;
    if (col_ptr >= w) col_ptr = w - 1;
    if (row_ptr >= h) row_ptr = h - 1;
    draining = (row_ptr == 0 && col_ptr == 0 && pending > 0);
    if (drain) begin
      if (!draining) return;
      if (pending > w + 1) pending = w + 1;
      if (pending == w + 1) begin
        r = h - 2;
        c = w - 1;
      end else begin
        r = h - 1;
        c = w - pending;
      end
      o = make_result(r, c, 0, 0, w, h);
      pending--;
      made = 1;
      return;
    end
    rr = row_ptr;
    cc = col_ptr;
    if (draining) begin
      pending = 0;
      sum_acc = 0;
    end
    if (pending >= w + 1) begin
      ok = 1;
      gr = 0;
      gc = 0;
      if (cc >= 1) begin
        if (rr < 1) begin ok = 0; r = 0; end else r = rr - 1;
        c = cc - 1;
      end else begin
        if (rr < 2) begin ok = 0; r = 0; end else r = rr - 2;
        c = w - 1;
      end
      if (ok && cc >= 2 && r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2) begin
        gr = sat_grad(prior_px - int'(older_mem[cc - 1]));
        gc = sat_grad(int'(recent_mem[cc]) - int'(older_mem[cc - 2]));
      end
      o = make_result(r, c, gr, gc, w, h);
      made = 1;
    end else begin
      pending++;
    end
    pc = (cc > 0) ? cc - 1 : w - 1;
    older_mem[pc] = recent_mem[pc];
    recent_mem[pc] = 16'(prior_px);
    prior_px = int'(px);
    if (cc + 1 >= w) begin
      col_ptr = 0;
      row_ptr = (rr + 1 >= h) ? 0 : rr + 1;
    end else begin
      col_ptr = cc + 1;
    end
  endfunction

  task automatic send_item(bit drain, logic [15:0] px, output bit made, output grad_result_t o);
    @(negedge clk);
    send_idle = (item_count < 250) ? 37 : (item_count < 500) ? 74 : 0;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    func <= drain;
    pixel <= px;
    do @(posedge clk); while (item_stall);
    gradient_step(drain, px, made, o);
    if (made) begin
      gradient_q.insert(gradient_q.size(), o);
      item_count++;
    end else if (!drain) begin
      item_count++;
    end
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_BITS'(data);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = data & 'h7FF;
      CFG_FRAME_HEIGHT: height_reg = data & 'h7FF;
      CFG_NORM_MODE:    l2_mode = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (gradient_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_frame(bit reconfig, int w, int h, bit mode, int kind, int style);
    int npix, ndrain;
    bit made;
    grad_result_t o;
    if (reconfig) begin
      wait_drained();
      cfg_write(CFG_FRAME_WIDTH, w);
      cfg_write(CFG_FRAME_HEIGHT, h);
      cfg_write(CFG_NORM_MODE, mode);
    end
    npix = clamp_dim(width_reg) * clamp_dim(height_reg);
    for (int i = 0; i < npix; i++) begin
      if (kind != 3 && $urandom_range(19) == 0) send_item(1'b1, 16'($urandom), made, o);
      case (kind)
        0: send_item(1'b0, 16'($urandom_range(65535)), made, o);
        1: send_item(1'b0, $urandom_range(1) ? 16'hFFFF : 16'h0000, made, o);
        default: send_item(1'b0, 16'($urandom_range(15)), made, o);
      endcase
    end
    case (style)
      0: ndrain = pending;
      1: ndrain = (pending > 0) ? $urandom_range(pending - 1) : 0;
      default: ndrain = pending + 2;
    endcase
    repeat (ndrain) send_item(1'b1, 16'($urandom), made, o);
    frame_count++;
  endtask

  // result check
  always @(posedge clk) begin
    grad_result_t e;
    if (!rst && result_valid && !result_stall) begin
      result_count++;
      if (gradient_q.size() == 0) begin
        report_mismatch("unexpected result row", out_row, -1);
      end else begin
        e = gradient_q.pop_front();
        if (out_row !== e.row) report_mismatch("out_row", out_row, e.row);
        if (out_col !== e.col) report_mismatch("out_col", out_col, e.col);
        if (grad_rows !== e.gr) report_mismatch("grad_rows", grad_rows, e.gr);
        if (grad_cols !== e.gc) report_mismatch("grad_cols", grad_cols, e.gc);
        if (magnitude !== e.mag) report_mismatch("magnitude", magnitude, e.mag);
        if (frame_sum !== e.sum) report_mismatch("frame_sum", frame_sum, e.sum);
        if (last_of_frame !== e.last) report_mismatch("last_of_frame", last_of_frame, e.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls, with one long hold-off
  always @(negedge clk) begin
    recv_idle = (item_count < 250) ? 74 : (item_count < 500) ? 37 : 0;
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    directed_row_t plan[15];
    bit made, reconfig, mode;
    grad_result_t o;
    int w, h, kind, style;
    bit held;
    plan = '{
      '{1, 16'h0000, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16'h0000, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16'h1234, 1, 0, 0, 0, 0, 0, 0},
      '{0, 16'h0000, 1, 0, 1, 0, 0, 0, 0},
      '{0, 16'h0000, 1, 0, 2, 0, 0, 0, 0},
      '{0, 16'hFFFF, 1, 1, 0, 0, 0, 0, 0},
      '{0, 16'h0000, 1, 1, 1, 65535, -65535, 131070, 0},
      '{1, 16'h0000, 1, 1, 2, 0, 0, 0, 0},
      '{1, 16'h0000, 1, 2, 0, 0, 0, 0, 0},
      '{1, 16'h0000, 1, 2, 1, 0, 0, 0, 0},
      '{1, 16'h0000, 1, 2, 2, 0, 0, 0, 1},
      '{1, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0}
    };
    rst = 1'b1;
    item_valid = 1'b0;
    func = 1'b0;
    pixel = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    hold_left = 0;
    mismatches = 0;
    item_count = 0;
    result_count = 0;
    frame_count = 0;
    foreach (older_mem[i]) older_mem[i] = '0;
    foreach (recent_mem[i]) recent_mem[i] = '0;
    prior_px = 0;
    row_ptr = 0;
    col_ptr = 0;
    pending = 0;
    sum_acc = 0;
    width_reg = DIM_LIMIT;
    height_reg = DIM_LIMIT;
    l2_mode = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_write(CFG_FRAME_WIDTH, 3);
    cfg_write(CFG_FRAME_HEIGHT, 3);
    cfg_write(CFG_NORM_MODE, 0);
    foreach (plan[i]) begin
      send_item(plan[i].drain, plan[i].px, made, o);
      if (plan[i].typed) begin
        if (!made) report_mismatch("table row gives no request", i, 1);
        else if (o.row != plan[i].row || o.col != plan[i].col || o.gr != plan[i].gr
                 || o.gc != plan[i].gc || o.mag != plan[i].mag || o.last != plan[i].last)
          report_mismatch("table row", i, o.mag);
      end
    end
    frame_count++;

    held = 0;
    while (item_count < 700) begin
      reconfig = $urandom_range(2) != 0;
      w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
      h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      mode = $urandom_range(1);
      kind = $urandom_range(2);
      style = ($urandom_range(5) == 0) ? 1 : ($urandom_range(5) == 0) ? 2 : 0;
      if (!held && item_count > 550) begin
        held = 1;
        hold_req = 1;
        kind = 3;
      end
      run_frame(reconfig, w, h, mode, kind, style);
    end
    // size extremes: both sizes below the minimum
    run_frame(1, 0, 1, 0, 1, 0);
    run_frame(1, 2, 0, 1, 1, 0);

    @(negedge clk);
    item_valid <= 1'b0;
    wait (gradient_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d frames, %0d counted input requests, %0d results checked",
             frame_count, item_count, result_count);
    $display("both norm modes, clamped sizes, partial drains and a long output hold-off");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cdg_pkg.sv
rtl/core/cdg_ram.sv
rtl/core/cdg_ctrl.sv
rtl/core/cdg_datapath.sv
rtl/core/central_difference_gradient_magnitude.sv
rtl/core/cdg_checker.sv
verif/tb_central_difference_gradient_magnitude.sv
